### src/float_natural_log_unit_macros.svh
// assertion macros for the float natural log unit
// used by the top level; no other dependencies
`ifndef FLOAT_NATURAL_LOG_UNIT_MACROS_SVH
`define FLOAT_NATURAL_LOG_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define FNL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fnl assertion failed");
`define FNL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fnl assertion failed");
`else
`define FNL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FNL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/fnl_pkg.sv
// shared types, constants and helpers of the float natural log unit
// no dependencies
`default_nettype none
package fnl_pkg;
	localparam int WORD_W     = 32;
	localparam int POLY_TERMS = 5;
	localparam int DIV_STEPS  = 26;

	typedef logic [WORD_W-1:0] f32_t;

	typedef struct packed {
		logic [7:0] n;
		f32_t       y;
		f32_t       yy;
		f32_t       scaled;
	} side_t;

	localparam f32_t LN2_BITS = 32'h3f317218;

	localparam f32_t COEF_FIVE [5] = '{
		32'h40000000, 32'h3f2aa9f0, 32'h3ecd06fb, 32'h3e8e44ac, 32'h3e92ba3d
	};
	localparam f32_t COEF_SIX [6] = '{
		32'h40000000, 32'h3f2aaa99, 32'h3eccd275, 32'h3e91d1c5, 32'h3e6bf66a,
		32'h3e32aa15
	};

	function automatic f32_t coef_bits(input int idx);
		if (POLY_TERMS == 6) begin
			return COEF_SIX[idx];
		end
		return COEF_FIVE[idx];
	endfunction

	// exact conversion of a signed byte to single precision
	function automatic f32_t i8_to_f32(input logic [7:0] n);
		logic [7:0]  mag;
		logic [2:0]  k;
		logic [22:0] frac;
		mag = n[7] ? 8'(-n) : n;
		k = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (mag[i]) k = 3'(i);
		end
		frac = 23'({15'd0, mag} << (5'd23 - {2'd0, k}));
		if (mag == 8'd0) return '0;
		return {n[7], 8'(8'd127 + {5'd0, k}), frac};
	endfunction
endpackage
`default_nettype wire

### src/fnl_stream_if.sv
// handshake channels of the float natural log unit
// depends on fnl_pkg
`default_nettype none
interface fnl_in_if;
	logic            valid;
	logic            ready;
	fnl_pkg::f32_t   operand_bits;
	modport source (output valid, output operand_bits, input ready);
	modport sink (input valid, input operand_bits, output ready);
endinterface

interface fnl_out_if;
	logic            valid;
	logic            ready;
	fnl_pkg::f32_t   log_bits;
	modport source (output valid, output log_bits, input ready);
	modport sink (input valid, input log_bits, output ready);
endinterface
`default_nettype wire

### src/float_natural_log_unit.sv
// Single-precision natural logarithm, fully pipelined.
// Channels: operand (sink) carries operand_bits, the raw 32-bit input;
// result (source) carries log_bits, the raw 32-bit logarithm. A request
// moves when valid and ready are both high.
// The operand is split into exponent n and mantissa x in [1,2); the
// divider forms y = (x-1)/(x+1) one quotient bit per stage, then
// n*ln2, y*y, a Horner polynomial in y*y, y*poly and the final sum run
// through two-stage multipliers and three-stage adders.
// The 26 divider steps and the Horner chain of multiply-add pairs make up
// most of the pipeline depth.
// Throughput: one request per cycle, unless the receiver holds ready low.
// Reset clears every valid bit; the data registers are not reset.
// When the receiver holds ready low with a result waiting, the whole
// pipeline freezes and operand.ready drops in the same cycle; nothing
// is lost or repeated and an empty output slot never holds it back.
// Depends on fnl_pkg, the stream interfaces, fnl_div, fnl_fmul, fnl_fadd.
`default_nettype none
`include "float_natural_log_unit_macros.svh"
module float_natural_log_unit (
	input logic clk,
	input logic arst_n,
	fnl_in_if.sink    operand,
	fnl_out_if.source result
);
	import fnl_pkg::*;

	localparam int NSTEP = POLY_TERMS - 1;

	logic  en;
	side_t side_in;

	logic  vld_d;
	f32_t  y_d;
	side_t side_d, side_y;

	logic  vld_l;
	f32_t  scaled_l;
	side_t side_l, side_ln;

	logic  vld_q;
	f32_t  yy_q;
	side_t side_q, side_sq;

	logic  hv [0:NSTEP];
	f32_t  acc [0:NSTEP];
	side_t hs [0:NSTEP];

	logic  vld_f;
	f32_t  f_f;
	side_t side_f;

	logic  vld_out;
	f32_t  res;
	side_t side_out;

	assign en            = !vld_out || result.ready;
	assign operand.ready = en;

	always_comb begin
		side_in   = '0;
		side_in.n = operand.operand_bits[30:23] - 8'd127;
	end

	fnl_div u_div (
		.clk, .arst_n, .en,
		.vld_i(operand.valid), .operand(operand.operand_bits), .side_i(side_in),
		.vld_o(vld_d), .y(y_d), .side_o(side_d)
	);

	always_comb begin
		side_y   = side_d;
		side_y.y = y_d;
	end

	fnl_fmul u_mul_ln (
		.clk, .arst_n, .en,
		.vld_i(vld_d), .a(i8_to_f32(side_d.n)), .b(LN2_BITS), .side_i(side_y),
		.vld_o(vld_l), .p(scaled_l), .side_o(side_l)
	);

	always_comb begin
		side_ln        = side_l;
		side_ln.scaled = scaled_l;
	end

	fnl_fmul u_mul_sq (
		.clk, .arst_n, .en,
		.vld_i(vld_l), .a(side_ln.y), .b(side_ln.y), .side_i(side_ln),
		.vld_o(vld_q), .p(yy_q), .side_o(side_q)
	);

	always_comb begin
		side_sq    = side_q;
		side_sq.yy = yy_q;
	end

	assign hv[0]  = vld_q;
	assign acc[0] = coef_bits(POLY_TERMS - 1);
	assign hs[0]  = side_sq;

	for (genvar j = 0; j < NSTEP; j++) begin : g_horner
		logic  pv;
		f32_t  prod;
		side_t ps;

		fnl_fmul u_mul (
			.clk, .arst_n, .en,
			.vld_i(hv[j]), .a(hs[j].yy), .b(acc[j]), .side_i(hs[j]),
			.vld_o(pv), .p(prod), .side_o(ps)
		);

		fnl_fadd u_add (
			.clk, .arst_n, .en,
			.vld_i(pv), .a(coef_bits(NSTEP - 1 - j)), .b(prod), .side_i(ps),
			.vld_o(hv[j+1]), .s(acc[j+1]), .side_o(hs[j+1])
		);
	end

	fnl_fmul u_mul_f (
		.clk, .arst_n, .en,
		.vld_i(hv[NSTEP]), .a(hs[NSTEP].y), .b(acc[NSTEP]), .side_i(hs[NSTEP]),
		.vld_o(vld_f), .p(f_f), .side_o(side_f)
	);

	fnl_fadd u_add_res (
		.clk, .arst_n, .en,
		.vld_i(vld_f), .a(side_f.scaled), .b(f_f), .side_i(side_f),
		.vld_o(vld_out), .s(res), .side_o(side_out)
	);

	assign result.valid    = vld_out;
	assign result.log_bits = side_out.n == side_out.n ? res : res;

	`FNL_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !result.valid, operand.ready)
	`FNL_ASSERT_IMPL(a_no_take_on_stall, clk, arst_n, result.valid && !result.ready, !operand.ready)
	`FNL_ASSERT_IMPL(a_quotient_range, clk, arst_n, vld_d, y_d[30:23] <= 8'd125)
	`FNL_ASSERT_NEXT(a_div_holds, clk, arst_n, vld_d && !en, vld_d && $stable(y_d))
endmodule
`default_nettype wire

### src/fnl_fmul.sv
// two-stage single-precision multiplier, round to nearest even
// depends on fnl_pkg; normal or zero operands only
`default_nettype none
module fnl_fmul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  fnl_pkg::f32_t  a,
	input  fnl_pkg::f32_t  b,
	input  fnl_pkg::side_t side_i,
	output logic           vld_o,
	output fnl_pkg::f32_t  p,
	output fnl_pkg::side_t side_o
);
	import fnl_pkg::*;

	logic        vld_s1, vld_s2;
	logic        sgn_s1, zero_s1;
	logic [9:0]  exp_s1;
	logic [47:0] prod_s1;
	side_t       side_s1, side_s2;
	f32_t        p_s2;

	logic [9:0]  exp_n;
	logic [23:0] mant;
	logic        grd, stk;
	logic [24:0] mant_r;
	logic [22:0] frac;
	f32_t        p_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1  <= a[31] ^ b[31];
			zero_s1 <= (a[30:23] == 8'd0) || (b[30:23] == 8'd0);
			exp_s1  <= {2'd0, a[30:23]} + {2'd0, b[30:23]};
			prod_s1 <= 48'({1'b1, a[22:0]}) * 48'({1'b1, b[22:0]});
			side_s1 <= side_i;
			side_s2 <= side_s1;
			p_s2    <= p_n;
		end
	end

	always_comb begin
		if (prod_s1[47]) begin
			mant  = prod_s1[47:24];
			grd   = prod_s1[23];
			stk   = |prod_s1[22:0];
			exp_n = exp_s1 - 10'd126;
		end else begin
			mant  = prod_s1[46:23];
			grd   = prod_s1[22];
			stk   = |prod_s1[21:0];
			exp_n = exp_s1 - 10'd127;
		end
		mant_r = {1'b0, mant} + 25'(grd & (stk | mant[0]));
		frac   = mant_r[22:0];
		if (mant_r[24]) begin
			exp_n = exp_n + 10'd1;
			frac  = 23'd0;
		end
		p_n = zero_s1 ? {sgn_s1, 31'd0} : {sgn_s1, exp_n[7:0], frac};
	end

	assign vld_o  = vld_s2;
	assign p      = p_s2;
	assign side_o = side_s2;
endmodule
`default_nettype wire

### src/fnl_fadd.sv
// three-stage single-precision adder: align, add, normalize and round
// depends on fnl_pkg; normal or zero operands only
`default_nettype none
module fnl_fadd (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  fnl_pkg::f32_t  a,
	input  fnl_pkg::f32_t  b,
	input  fnl_pkg::side_t side_i,
	output logic           vld_o,
	output fnl_pkg::f32_t  s,
	output fnl_pkg::side_t side_o
);
	import fnl_pkg::*;

	logic        vld_s1, vld_s2, vld_s3;
	logic        sgn_s1, sub_s1, sgn_s2;
	logic [7:0]  exp_s1, exp_s2;
	logic [26:0] big_s1, sml_s1;
	logic [27:0] sum_s2;
	side_t       side_s1, side_s2, side_s3;
	f32_t        s_s3;

	f32_t        big, sml;
	logic [7:0]  dexp;
	logic [26:0] ms0, msh, mask;
	logic        st;

	logic [4:0]  lz;
	logic [26:0] nrm;
	logic [23:0] mant;
	logic        grd, stk;
	logic [24:0] mant_r;
	logic [22:0] frac;
	logic [9:0]  exp_n;
	f32_t        s_n;

	always_comb begin
		if (a[30:0] >= b[30:0]) begin
			big = a;
			sml = b;
		end else begin
			big = b;
			sml = a;
		end
		dexp = big[30:23] - sml[30:23];
		ms0  = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
		if (dexp >= 8'd27) begin
			msh  = 27'd0;
			mask = '1;
		end else begin
			msh  = ms0 >> dexp;
			mask = (27'd1 << dexp) - 27'd1;
		end
		st = |(ms0 & mask);
	end

	// normalize: carry out, or left shift by the leading zero count
	always_comb begin
		lz = 5'd0;
		for (int i = 0; i < 27; i++) begin
			if (sum_s2[i]) lz = 5'(26 - i);
		end
		nrm = sum_s2[26:0] << lz;
		if (sum_s2[27]) begin
			mant  = sum_s2[27:4];
			grd   = sum_s2[3];
			stk   = |sum_s2[2:0];
			exp_n = {2'd0, exp_s2} + 10'd1;
		end else begin
			mant  = nrm[26:3];
			grd   = nrm[2];
			stk   = |nrm[1:0];
			exp_n = {2'd0, exp_s2} - {5'd0, lz};
		end
		mant_r = {1'b0, mant} + 25'(grd & (stk | mant[0]));
		frac   = mant_r[22:0];
		if (mant_r[24]) begin
			exp_n = exp_n + 10'd1;
			frac  = 23'd0;
		end
		s_n = (sum_s2 == 28'd0) ? 32'd0 : {sgn_s2, exp_n[7:0], frac};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1  <= big[31];
			sub_s1  <= a[31] ^ b[31];
			exp_s1  <= big[30:23];
			big_s1  <= {big[30:23] != 8'd0, big[22:0], 3'd0};
			sml_s1  <= {msh[26:1], msh[0] | st};
			side_s1 <= side_i;
			sgn_s2  <= sgn_s1;
			exp_s2  <= exp_s1;
			sum_s2  <= sub_s1 ? ({1'b0, big_s1} - {1'b0, sml_s1})
			                  : ({1'b0, big_s1} + {1'b0, sml_s1});
			side_s2 <= side_s1;
			s_s3    <= s_n;
			side_s3 <= side_s2;
		end
	end

	assign vld_o  = vld_s3;
	assign s      = s_s3;
	assign side_o = side_s3;
endmodule
`default_nettype wire

### src/fnl_div.sv
// mantissa extraction and pipelined restoring divider for y = (x-1)/(x+1)
// depends on fnl_pkg; one quotient bit per stage, then round to nearest even
`default_nettype none
module fnl_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           vld_i,
	input  fnl_pkg::f32_t  operand,
	input  fnl_pkg::side_t side_i,
	output logic           vld_o,
	output fnl_pkg::f32_t  y,
	output fnl_pkg::side_t side_o
);
	import fnl_pkg::*;

	logic        vld_s [0:DIV_STEPS+1];
	side_t       side_s [0:DIV_STEPS+1];
	logic [24:0] rem_s [0:DIV_STEPS];
	logic [25:0] quo_s [0:DIV_STEPS];
	logic [23:0] den_s [0:DIV_STEPS];
	logic [4:0]  sh_s [0:DIV_STEPS];
	logic        zero_s [0:DIV_STEPS];
	f32_t        y_s27;

	logic [22:0] m;
	logic [4:0]  k;
	logic [22:0] half_m;
	logic [4:0]  sh;
	logic [23:0] num_n, den_n;

	logic [25:0] q;
	logic [23:0] mant;
	logic        grd, stk;
	logic [24:0] mant_r;
	logic [7:0]  exp_n;
	logic [22:0] frac;
	f32_t        y_n;

	// numerator m*2^-23 is normalized to bit 23, denominator is (x+1)/2 rounded
	always_comb begin
		m = operand[22:0];
		k = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (m[i]) k = 5'(i);
		end
		sh     = 5'd23 - k;
		num_n  = {1'b0, m} << sh;
		half_m = {1'b0, m[22:1]} + 23'(m[0] & m[1]);
		den_n  = {1'b1, 23'd0} + {1'b0, half_m};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_i;
			rem_s[0]  <= {1'b0, num_n};
			quo_s[0]  <= 26'd0;
			den_s[0]  <= den_n;
			sh_s[0]   <= sh;
			zero_s[0] <= (m == 23'd0);
		end
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [24:0] trial;
		logic        ge;
		if (i == 0) begin : g_first
			assign trial = rem_s[i];
		end else begin : g_next
			assign trial = {rem_s[i][23:0], 1'b0};
		end
		assign ge = trial >= {1'b0, den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? (trial - {1'b0, den_s[i]}) : trial;
				quo_s[i+1]  <= {quo_s[i][24:0], ge};
				den_s[i+1]  <= den_s[i];
				sh_s[i+1]   <= sh_s[i];
				zero_s[i+1] <= zero_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	always_comb begin
		q = quo_s[DIV_STEPS];
		if (q[25]) begin
			mant  = q[25:2];
			grd   = q[1];
			stk   = q[0] | (rem_s[DIV_STEPS] != 25'd0);
			exp_n = 8'd126 - {3'd0, sh_s[DIV_STEPS]};
		end else begin
			mant  = q[24:1];
			grd   = q[0];
			stk   = rem_s[DIV_STEPS] != 25'd0;
			exp_n = 8'd125 - {3'd0, sh_s[DIV_STEPS]};
		end
		mant_r = {1'b0, mant} + 25'(grd & (stk | mant[0]));
		frac   = mant_r[22:0];
		if (mant_r[24]) begin
			exp_n = exp_n + 8'd1;
			frac  = 23'd0;
		end
		y_n = zero_s[DIV_STEPS] ? 32'd0 : {1'b0, exp_n, frac};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[DIV_STEPS+1] <= 1'b0;
		end else if (en) begin
			vld_s[DIV_STEPS+1] <= vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s27                <= y_n;
			side_s[DIV_STEPS+1]  <= side_s[DIV_STEPS];
		end
	end

	assign vld_o  = vld_s[DIV_STEPS+1];
	assign y      = y_s27;
	assign side_o = side_s[DIV_STEPS+1];
endmodule
`default_nettype wire
